/* hdl/pls_pkg.sv */
// pls_pkg: shared types and constants for the positional list store
// no dependencies
package pls_pkg;

  localparam int CMD_W     = 3;
  localparam int POS_W     = 5;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 5;
  localparam int LIMIT_W   = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LENGTH  = 3'd5;

  // broadcast to every cell of the row
  typedef struct packed {
    logic             insert;  // cells above index take their lower neighbor
    logic             remove;  // cells at or above index take their upper neighbor
    logic             load;    // cell at index takes the new value
    logic [POS_W-1:0] index;   // 0-based target slot
  } cell_ctl_t;

endpackage

/* hdl/pls_if.sv */
// pls_cmd_if, pls_rsp_if: valid/ready channels for commands and results
// depends on pls_pkg
interface pls_cmd_if import pls_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface pls_rsp_if import pls_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] read_data;
  logic               status;
  logic [COUNT_W-1:0] count;
  logic               is_empty;

  modport source (output valid, output read_data, output status, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_data, input status, input count,
                  input is_empty, output ready);
endinterface

/* hdl/pls_cell.sv */
// pls_cell: one storage slot of the list row
// depends on pls_pkg
module pls_cell import pls_pkg::*; #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] din,
  input  logic [DATA_WIDTH-1:0] lower,
  input  logic [DATA_WIDTH-1:0] upper,
  output logic [DATA_WIDTH-1:0] entry
);

  localparam logic [31:0] MY_IDX = 32'(IDX);

  logic [31:0] k32;
  assign k32 = 32'(ctl.index);

  always_ff @(posedge clk) begin
    if (ctl.load && (MY_IDX == k32)) begin
      entry <= din;
    end else if (ctl.insert && (MY_IDX > k32)) begin
      entry <= lower;
    end else if (ctl.remove && (MY_IDX >= k32)) begin
      entry <= upper;
    end
  end

endmodule

/* hdl/pls_ctrl.sv */
// pls_ctrl: command decode, entry count, limit register and result register
// depends on pls_pkg
module pls_ctrl import pls_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [LIMIT_W-1:0]                cfg_wdata,
  input  logic                              accept,
  input  logic [CMD_W-1:0]                  cmd,
  input  logic [POS_W-1:0]                  position,
  input  logic [VALUE_W-1:0]                rd_entry,
  output cell_ctl_t                         ctl,
  output logic [$clog2(CAPACITY+1)-1:0]     cnt,
  output logic [VALUE_W-1:0]                read_data,
  output logic                              status,
  output logic [COUNT_W-1:0]                count,
  output logic                              is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]   cnt_next;
  logic [LIMIT_W-1:0] limit;
  logic [31:0]        pos32, cnt32, lim32, cn32;
  logic               in_list, ins_ok, err;
  logic [VALUE_W-1:0] rd;

  always_comb begin
    pos32   = 32'(position);
    cnt32   = 32'(cnt);
    lim32   = 32'(limit);
    in_list = (pos32 >= 32'd1) && (pos32 <= cnt32);
    ins_ok  = (pos32 >= 32'd1) && (pos32 <= cnt32 + 32'd1) && (cnt32 < lim32) &&
              (cnt32 < 32'(CAPACITY));
    err      = 1'b0;
    rd       = '0;
    cnt_next = cnt;
    ctl        = '0;
    ctl.index  = position - POS_W'(1);
    unique case (cmd)
      CMD_INSERT: begin
        if (ins_ok) begin
          ctl.insert = accept;
          ctl.load   = accept;
          cnt_next   = cnt + CNT_W'(1);
        end else begin
          err = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (in_list) begin
          ctl.remove = accept;
          cnt_next   = cnt - CNT_W'(1);
        end else begin
          err = 1'b1;
        end
      end
      CMD_GET: begin
        if (in_list) begin
          rd = rd_entry;
        end else begin
          err = 1'b1;
        end
      end
      CMD_REPLACE: begin
        if (in_list) begin
          ctl.load = accept;
        end else begin
          err = 1'b1;
        end
      end
      CMD_CLEAR: begin
        cnt_next = '0;
      end
      CMD_LENGTH: begin
        cnt_next = cnt;
      end
      default: begin
        err = 1'b1;
      end
    endcase
    cn32 = 32'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      limit <= LIMIT_RESET;
    end else begin
      if (accept) begin
        cnt <= cnt_next;
      end
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= rd;
      status    <= err;
      count     <= cn32[COUNT_W-1:0];
      is_empty  <= (cnt_next == '0);
    end
  end

endmodule

/* hdl/positional_list_store.sv */
// positional_list_store: bounded list addressed by 1-based position
// result: registered, valid in the cycle after the command transfer
// throughput: one command per cycle while the result channel is ready; every cell of the row shifts in the same cycle
// reset: entry count cleared, limit set to 16, entry contents undefined until written
// depends on pls_pkg, pls_if, pls_cell, pls_ctrl
module positional_list_store import pls_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  pls_cmd_if.sink            in_ch,
  pls_rsp_if.source          out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                  accept;
  logic                  out_valid;
  cell_ctl_t             ctl;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] din;
  logic [63:0]           val64, rd64;
  logic [31:0]           idx32;
  logic [IDX_W-1:0]      rd_idx;
  logic [VALUE_W-1:0]    rd_entry;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  // output register parts the two sides: a new transfer is taken when the
  // result slot is empty or being drained this cycle
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end
  assign out_ch.valid = out_valid;

  // value kept in its low DATA_WIDTH bits
  assign val64 = 64'(in_ch.value);
  assign din   = val64[DATA_WIDTH-1:0];

  // read port for get; out-of-range slots are masked by the decode
  assign idx32    = 32'(ctl.index);
  assign rd_idx   = idx32[IDX_W-1:0];
  assign rd64     = 64'(cell_q[rd_idx]);
  assign rd_entry = rd64[VALUE_W-1:0];

  pls_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .cmd       (in_ch.cmd),
    .position  (in_ch.position),
    .rd_entry  (rd_entry),
    .ctl       (ctl),
    .cnt       (cnt),
    .read_data (out_ch.read_data),
    .status    (out_ch.status),
    .count     (out_ch.count),
    .is_empty  (out_ch.is_empty)
  );

  // row of cells; each one sees its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = din;  // slot zero never shifts up
    end else begin : g_mid_lo
      assign lower = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_q[i];  // top slot keeps its word on remove
    end else begin : g_mid_hi
      assign upper = cell_q[i+1];
    end
    pls_cell #(.IDX(i), .DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .din   (din),
      .lower (lower),
      .upper (upper),
      .entry (cell_q[i])
    );
  end

  // count never runs past the row
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  // every transfer in yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.valid)
    else $error("missing result after command transfer");

  // clear always succeeds and empties the list
  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && (in_ch.cmd == CMD_CLEAR) |=>
      (out_ch.count == '0) && !out_ch.status && out_ch.is_empty && (cnt == '0))
    else $error("clear did not empty the list");

  // cells only move on a transfer
  a_ctl_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |-> !(ctl.insert || ctl.remove || ctl.load))
    else $error("cell row changed without a transfer");

endmodule

/* dv/positional_list_store_tb.sv */
// positional_list_store_tb: self-checking bench for the positional list store
// depends on pls_pkg, pls_if (pls_cmd_if, pls_rsp_if) and positional_list_store
module positional_list_store_tb;
  import pls_pkg::*;

  localparam int LIST_DEPTH = 16;

  // command codes the block treats as unused
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // one result transfer as seen on the output channel
  typedef struct packed {
    logic [VALUE_W-1:0] read_data;
    logic               status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } list_result_t;

  // mirror of the list plus the queue of results still owed by the block
  class list_scoreboard;
    logic [VALUE_W-1:0] cells [LIST_DEPTH];
    int unsigned        fill;
    int unsigned        limit;
    list_result_t       awaited [$];
    int unsigned        mismatches;

    function new();
      fill       = 0;
      limit      = LIMIT_RESET;
      mismatches = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = v;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // predict the result of one accepted command and update the mirror
    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] position,
                               logic [VALUE_W-1:0] value);
      list_result_t r;
      int           p;
      int           i;
      int unsigned  room;
      bit           held;
      p    = position;
      room = (limit > LIST_DEPTH) ? LIST_DEPTH : limit;
      held = (p >= 1) && (p <= fill);
      r    = '0;
      case (cmd)
        CMD_INSERT: begin
          if (p >= 1 && p <= fill + 1 && fill < room) begin
            for (i = fill; i >= p; i--) cells[i] = cells[i-1];
            cells[p-1] = value;
            fill++;
          end else begin
            r.status = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (held) begin
            for (i = p; i < fill; i++) cells[i-1] = cells[i];
            fill--;
          end else begin
            r.status = 1'b1;
          end
        end
        CMD_GET: begin
          if (held) r.read_data = cells[p-1];
          else r.status = 1'b1;
        end
        CMD_REPLACE: begin
          if (held) cells[p-1] = value;
          else r.status = 1'b1;
        end
        CMD_CLEAR: fill = 0;
        CMD_LENGTH: ;
        default: r.status = 1'b1;
      endcase
      r.count    = fill[COUNT_W-1:0];
      r.is_empty = (fill == 0);
      awaited.push_back(r);
    endfunction

    // compare one result transfer against the oldest prediction
    function void check_result(list_result_t got);
      list_result_t want;
      bit           bad;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result data %h status %0d count %0d empty %0d",
                 $time, got.read_data, got.status, got.count, got.is_empty);
        return;
      end
      want = awaited.pop_front();
      bad  = 1'b0;
      if (got.read_data !== want.read_data) begin
        bad = 1'b1;
        $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                 got.read_data);
      end
      if (got.status !== want.status) begin
        bad = 1'b1;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.count !== want.count) begin
        bad = 1'b1;
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
      end
      if (got.is_empty !== want.is_empty) begin
        bad = 1'b1;
        $display("%0t: is_empty expected %0d actual %0d", $time, want.is_empty,
                 got.is_empty);
      end
      if (bad) mismatches++;
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  pls_cmd_if in_ch ();
  pls_rsp_if out_ch ();

  list_scoreboard board;

  positional_list_store #(
    .CAPACITY   (LIST_DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // free-running clock, 4 units per period
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs on a handshake
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // present one command and hold it until the block takes it
  // called at a rising edge, returns at the edge of the transfer
  task automatic offer(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] position,
                       logic [VALUE_W-1:0] value);
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.position <= position;
    in_ch.value    <= value;
    do @(posedge clk); while (!in_ch.ready);
    board.note_command(cmd, position, value);
  endtask

  // drop valid and let every owed result drain out before touching the limit
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // single-edge write of the capacity limit, only while the list is idle
  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_limit(v);
  endtask

  // mostly well-formed commands aimed at live positions, plus some noise
  task automatic choose_command(output logic [CMD_W-1:0] cmd,
                                output logic [POS_W-1:0] position,
                                output logic [VALUE_W-1:0] value);
    int unsigned pick;
    int unsigned top;
    pick     = $urandom_range(0, 99);
    top      = (board.fill == 0) ? 1 : board.fill;
    value    = $urandom;
    position = POS_W'($urandom_range(0, 31));
    if (pick < 3) begin
      cmd = CMD_CLEAR;
    end else if (pick < 6) begin
      cmd = CMD_LENGTH;
    end else if (pick < 9) begin
      cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
    end else if (pick < 15) begin
      // any legal code with an arbitrary position
      cmd = CMD_W'($urandom_range(0, 5));
    end else if (pick < 50) begin
      // inserts lead removes so the list climbs to its limit
      cmd      = CMD_INSERT;
      position = POS_W'($urandom_range(1, board.fill + 1));
    end else if (pick < 67) begin
      cmd      = CMD_REMOVE;
      position = POS_W'($urandom_range(1, top));
    end else if (pick < 85) begin
      cmd      = CMD_GET;
      position = POS_W'($urandom_range(1, top));
    end else begin
      cmd      = CMD_REPLACE;
      position = POS_W'($urandom_range(1, top));
    end
  endtask

  // bursts of back-to-back transfers separated by random gaps
  task automatic run_random(int unsigned n);
    int unsigned        sent;
    int unsigned        burst;
    int unsigned        gap;
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    sent = 0;
    while (sent < n) begin
      // now and then a long unbroken stretch
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      while (burst > 0 && sent < n) begin
        choose_command(cmd, position, value);
        offer(cmd, position, value);
        burst--;
        sent++;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // result side: check every transfer, ready follows its own pattern
  // each window picks a mode; every eighth window is a full hold-off
  // so the block fills up and pushes back on the command side
  initial begin : result_sink
    int unsigned  cyc;
    int unsigned  win;
    int unsigned  mode;
    list_result_t got;
    cyc  = 0;
    win  = 0;
    mode = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.read_data = out_ch.read_data;
        got.status    = out_ch.status;
        got.count     = out_ch.count;
        got.is_empty  = out_ch.is_empty;
        board.check_result(got);
      end
      if (cyc % 50 == 0) begin
        win++;
        mode = (win % 8 == 3) ? 3 : $urandom_range(0, 2);
      end
      cyc++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= 1'b0;
      endcase
    end
  end

  // main sequence
  initial begin : stimulus
    logic [LIMIT_W-1:0] phase_limits [8];
    int                 k;
    board = new();

    // every block input known from time zero
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_LENGTH;
    in_ch.position <= '0;
    in_ch.value    <= '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part on a two-entry list so the full case comes early
    write_limit(5'd2);
    offer(CMD_INSERT, 5'd0, 32'h0000_0005);    // position zero rejected
    offer(CMD_INSERT, 5'd1, 32'h0000_0000);
    offer(CMD_INSERT, 5'd2, 32'hffff_ffff);    // append at count+1
    offer(CMD_INSERT, 5'd1, 32'ha5a5_a5a5);    // full list rejected
    offer(CMD_GET, 5'd1, 32'h0);
    offer(CMD_GET, 5'd2, 32'h0);
    offer(CMD_GET, 5'd0, 32'h0);
    offer(CMD_GET, 5'd31, 32'h0);
    offer(CMD_REPLACE, 5'd2, 32'h5a5a_5a5a);
    offer(CMD_REPLACE, 5'd0, 32'h1234_5678);
    offer(CMD_REMOVE, 5'd3, 32'h0);            // past the end
    offer(CMD_REMOVE, 5'd1, 32'h0);            // later entry shifts down
    offer(CMD_INSERT, 5'd3, 32'h0bad_0bad);    // count+2 rejected
    offer(CMD_INSERT, 5'd2, 32'h1234_5678);
    offer(CMD_GET, 5'd2, 32'h0);
    offer(CMD_INSERT, 5'd31, 32'hffff_ffff);
    offer(CMD_LENGTH, 5'd31, 32'hffff_ffff);
    offer(CMD_SPARE_LO, 5'd1, 32'h0);
    offer(CMD_SPARE_HI, 5'd31, 32'hffff_ffff);
    offer(CMD_CLEAR, 5'd0, 32'h0);
    offer(CMD_GET, 5'd1, 32'h0);               // get, remove and replace all fail on an empty list
    offer(CMD_REMOVE, 5'd1, 32'h0);
    offer(CMD_REPLACE, 5'd1, 32'h0);
    offer(CMD_LENGTH, 5'd0, 32'h0);
    drain();

    // limit above capacity, reset value, lowered under a likely full list,
    // zero, one, just above capacity, mid value, then anything
    phase_limits = '{5'd31, 5'd16, 5'd4, 5'd0, 5'd1, 5'd17, 5'd8, 5'd0};
    phase_limits[7] = LIMIT_W'($urandom_range(0, 31));
    for (k = 0; k < 8; k++) begin
      write_limit(phase_limits[k]);
      run_random(175);
      drain();
    end

    // short settle for anything still in flight
    repeat (5) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* positional_list_store.f */
hdl/pls_pkg.sv
hdl/pls_if.sv
hdl/pls_cell.sv
hdl/pls_ctrl.sv
hdl/positional_list_store.sv
dv/positional_list_store_tb.sv
